/* rtl/url_percent_decoder_assert.svh */
// Assertion macros for the URL percent decoder.
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define UPD_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define UPD_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);
`else
`define UPD_ASSERT_IMPLY(lbl, ante, cons, msg)
`define UPD_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

/* rtl/upd_pkg.sv */
// Shared types and constants for the URL percent decoder.
`default_nettype none
package upd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;
		logic            last;
	} upd_entry_t;

endpackage
`default_nettype wire

/* rtl/upd_front.sv */
// Front end: escape tracking and expansion of one input byte into a queue entry.
`default_nettype none
module upd_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         in_byte,
	input  wire logic               in_last,
	input  wire logic               q_full,
	output logic                    q_push,
	output upd_pkg::upd_entry_t     q_entry
);
	import upd_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_DIG} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] held_q, held_d;
	upd_entry_t ent;
	logic       accept;

	function automatic logic is_hex(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
			(b >= 8'h41 && b <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] b);
		return (b <= 8'h39) ? b[3:0] : b[3:0] + 4'd9;
	endfunction

	function automatic upd_entry_t add(input upd_entry_t e, input logic [7:0] x);
		upd_entry_t r;
		r = e;
		if (r.cnt != 2'd3) begin
			r.bytes[r.cnt] = x;
			r.cnt = r.cnt + 2'd1;
		end
		return r;
	endfunction

	always_comb begin
		ent     = '0;
		phase_d = PH_IDLE;
		held_d  = held_q;
		unique case (phase_q)
			PH_PCT: begin
				if (is_hex(in_byte)) begin
					held_d  = in_byte;
					phase_d = PH_DIG;
				end else begin
					ent = add(ent, CH_PERCENT);
					if (in_byte == CH_PERCENT) phase_d = PH_PCT;
					else ent = add(ent, (in_byte == CH_PLUS) ? CH_SPACE : in_byte);
				end
			end
			PH_DIG: begin
				if (is_hex(in_byte)) begin
					ent = add(ent, {hex_val(held_q), hex_val(in_byte)});
				end else begin
					ent = add(ent, CH_PERCENT);
					ent = add(ent, held_q);
					if (in_byte == CH_PERCENT) phase_d = PH_PCT;
					else ent = add(ent, (in_byte == CH_PLUS) ? CH_SPACE : in_byte);
				end
			end
			default: begin
				if (in_byte == CH_PERCENT) phase_d = PH_PCT;
				else ent = add(ent, (in_byte == CH_PLUS) ? CH_SPACE : in_byte);
			end
		endcase
		if (in_last) begin
			if (phase_d == PH_PCT) begin
				ent = add(ent, CH_PERCENT);
			end else if (phase_d == PH_DIG) begin
				ent = add(ent, CH_PERCENT);
				ent = add(ent, held_d);
			end
			phase_d  = PH_IDLE;
			ent.last = 1'b1;
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && (ent.cnt != 2'd0);
	assign q_entry  = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/upd_fifo.sv */
// Entry queue between front end and back end.
`default_nettype none
module upd_fifo #(
	parameter int Depth = upd_pkg::FIFO_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire upd_pkg::upd_entry_t wr_entry,
	input  wire logic                pop,
	output upd_pkg::upd_entry_t      head,
	output logic                     full,
	output logic                     empty
);
	import upd_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	upd_entry_t    mem_q [Depth];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(Depth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (do_push && !do_pop) count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

/* rtl/upd_back.sv */
// Back end: serializes queue entries into the registered output stream.
`default_nettype none
module upd_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire upd_pkg::upd_entry_t head,
	input  wire logic                empty,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [7:0]               out_byte,
	output logic                     out_last
);
	import upd_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       load;
	logic       end_of_entry;

	assign load         = !empty && (!valid_q || out_ready);
	assign end_of_entry = (idx_q == head.cnt - 2'd1);
	assign pop          = load && end_of_entry;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.bytes[idx_q];
			last_q <= head.last && end_of_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
			if (load) idx_q <= end_of_entry ? 2'd0 : idx_q + 2'd1;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

endmodule
`default_nettype wire

/* rtl/url_percent_decoder.sv */
// Decoded bytes pass through the entry queue and then the output register.
// Throughput: one input byte per cycle, one output byte per cycle while m_tready is high.
// An escape error or end of string can expand one input byte into up to three output bytes;
// the entry queue absorbs these and holds off the input only when it is full.
// Reset: arst_n asynchronously clears escape state, queue pointers and output valid.
`default_nettype none
`include "url_percent_decoder_assert.svh"
module url_percent_decoder #(
	parameter int FifoDepth = upd_pkg::FIFO_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // [7:0] in_byte
	input  wire logic       s_tlast,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,  // [7:0] out_byte
	output logic            m_tlast
);
	import upd_pkg::*;

	upd_entry_t push_entry, head;
	logic       push, pop, full, empty;

	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.q_full   (full),
		.q_push   (push),
		.q_entry  (push_entry)
	);

	upd_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	upd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

	`UPD_ASSERT_IMPLY(a_push_nonempty, push, push_entry.cnt != 2'd0, "empty entry queued")
	`UPD_ASSERT_IMPLY(a_last_has_byte, s_tvalid && s_tready && s_tlast, push, "end of string lost")
	`UPD_ASSERT_NEVER(a_pop_empty, pop && empty, "pop from empty queue")
	`UPD_ASSERT_IMPLY(a_pop_slot_free, pop, !m_tvalid || m_tready, "pop while output stalled")

endmodule
`default_nettype wire
